// File: src/gsf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the gzip stored-block framer.
// No dependencies; front, queue, back end and top import this package.
package gsf_pkg;

  localparam int unsigned MAX_BLOCK_BYTES_DEF = 65535;
  localparam int unsigned QUEUE_DEPTH_DEF     = 2;

  localparam int unsigned HDR_BYTES = 10;
  localparam int unsigned BLK_BYTES = 5;
  localparam int unsigned TRL_BYTES = 8;

  localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
  localparam logic [31:0] CRC_POLY = 32'hedb8_8320;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } gsf_op_t;

  typedef struct packed {
    logic        hdr_en;
    logic        blk_en;
    logic        blk_final;
    logic [15:0] blk_len;
    logic        data_en;
    logic [7:0]  data_byte;
    logic        trl_en;
    logic [31:0] trl_crc;
    logic [31:0] trl_count;
  } gsf_job_t;

endpackage

// File: src/gsf_intf.sv
`timescale 1ns / 1ps
// Channel interfaces of the gzip stored-block framer: input items,
// result bytes and the length register write. No dependencies.
interface gsf_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface gsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_end;
  modport source (output valid, output out_byte, output last_of_run, output stream_end,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_run, input stream_end,
                output ready);
endinterface

interface gsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_length;
  modport source (output valid, output total_length, input ready);
  modport sink (input valid, input total_length, output ready);
endinterface

// File: src/gsf_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transactions, keeps CRC and counters and turns each
// start and in-range data byte into an emit job. Depends on gsf_pkg and gsf_in_if.
module gsf_front
  import gsf_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gsf_in_if.sink      in_ch,
  input  logic [31:0] total_length,
  output logic        push_valid,
  input  logic        push_ready,
  output gsf_job_t    push_data
);

  localparam logic [31:0] MAX_LEN = 32'(MAX_BLOCK_BYTES);

  logic [31:0] crc_r, crc_nxt;
  logic [31:0] seen_r, seen_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic        active_r, active_nxt;

  logic [32:0] left_w;
  logic        no_room;
  logic        last_byte;
  logic        fits;
  logic [15:0] chunk;
  logic [31:0] crc_upd;
  logic        accept;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  assign left_w    = {1'b0, total_length} - {1'b0, seen_r};
  assign no_room   = left_w[32] || (left_w[31:0] == 32'd0);
  assign last_byte = left_w[31:0] == 32'd1;
  assign fits      = left_w[31:0] <= MAX_LEN;
  assign chunk     = fits ? left_w[15:0] : MAX_LEN[15:0];
  assign crc_upd   = crc_byte(crc_r, in_ch.data_byte);

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign push_valid  = in_ch.valid &&
                       ((in_ch.operation == OP_START) || (active_r && !no_room));

  always_comb begin
    crc_nxt    = crc_r;
    seen_nxt   = seen_r;
    rem_nxt    = rem_r;
    active_nxt = active_r;
    push_data  = '0;
    if (in_ch.operation == OP_START) begin
      crc_nxt          = CRC_INIT;
      seen_nxt         = 32'd0;
      rem_nxt          = 16'd0;
      active_nxt       = total_length != 32'd0;
      push_data.hdr_en = 1'b1;
      if (total_length == 32'd0) begin
        push_data.blk_en    = 1'b1;
        push_data.blk_final = 1'b1;
        push_data.trl_en    = 1'b1;
      end
    end else if (active_r) begin
      if (no_room) begin
        active_nxt = 1'b0;
      end else begin
        push_data.data_en   = 1'b1;
        push_data.data_byte = in_ch.data_byte;
        crc_nxt             = crc_upd;
        seen_nxt            = seen_r + 32'd1;
        if (rem_r == 16'd0) begin
          push_data.blk_en    = 1'b1;
          push_data.blk_final = fits;
          push_data.blk_len   = chunk;
          rem_nxt             = chunk - 16'd1;
        end else begin
          rem_nxt = rem_r - 16'd1;
        end
        if (last_byte) begin
          push_data.trl_en    = 1'b1;
          push_data.trl_crc   = ~crc_upd;
          push_data.trl_count = seen_r + 32'd1;
          active_nxt          = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= CRC_INIT;
      seen_r   <= 32'd0;
      rem_r    <= 16'd0;
      active_r <= 1'b0;
    end else if (accept) begin
      crc_r    <= crc_nxt;
      seen_r   <= seen_nxt;
      rem_r    <= rem_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// File: src/gsf_queue.sv
`timescale 1ns / 1ps
// Small register queue of emit jobs between front and back end.
// Depends on gsf_pkg.
module gsf_queue
  import gsf_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  gsf_job_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output gsf_job_t pop_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  gsf_job_t      mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   count_r;
  logic          do_push, do_pop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = count_r != (AW + 1)'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: src/gsf_back.sv
`timescale 1ns / 1ps
// Back end: steps through the header, block header, data byte and trailer that each job enables, one
// byte per cycle into out_byte_r unless stalled. Depends on gsf_pkg, gsf_out_if.
module gsf_back
  import gsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  gsf_job_t  pop_data,
  gsf_out_if.source out_ch
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HDR  = 5'b00010,
    S_BLK  = 5'b00100,
    S_DAT  = 5'b01000,
    S_TRL  = 5'b10000
  } phase_t;

  phase_t      state_r, state_nxt;
  logic [3:0]  idx_r, idx_nxt;
  gsf_job_t    job_r, job_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        last_r, last_nxt;
  logic        end_r, end_nxt;

  logic        adv;
  logic [7:0]  cur_byte;
  logic        phase_done;
  phase_t      next_ph;

  function automatic logic [7:0] hdr_byte(input logic [3:0] i);
    logic [7:0] b;
    unique case (i)
      4'd0:    b = 8'h1f;
      4'd1:    b = 8'h8b;
      4'd2:    b = 8'h08;
      4'd9:    b = 8'hff;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic phase_t first_phase(input gsf_job_t j);
    phase_t p;
    priority if (j.hdr_en) p = S_HDR;
    else if (j.blk_en) p = S_BLK;
    else if (j.data_en) p = S_DAT;
    else p = S_TRL;
    return p;
  endfunction

  function automatic phase_t after(input gsf_job_t j, input phase_t p);
    phase_t n;
    n = S_IDLE;
    if (p == S_HDR && j.blk_en) begin
      n = S_BLK;
    end else if ((p == S_HDR || p == S_BLK) && j.data_en) begin
      n = S_DAT;
    end else if ((p == S_HDR || p == S_BLK || p == S_DAT) && j.trl_en) begin
      n = S_TRL;
    end
    return n;
  endfunction

  always_comb begin
    cur_byte   = 8'h00;
    phase_done = 1'b0;
    unique case (state_r)
      S_HDR: begin
        cur_byte   = hdr_byte(idx_r);
        phase_done = idx_r == 4'(HDR_BYTES - 1);
      end
      S_BLK: begin
        unique case (idx_r)
          4'd0:    cur_byte = {7'd0, job_r.blk_final};
          4'd1:    cur_byte = job_r.blk_len[7:0];
          4'd2:    cur_byte = job_r.blk_len[15:8];
          4'd3:    cur_byte = ~job_r.blk_len[7:0];
          default: cur_byte = ~job_r.blk_len[15:8];
        endcase
        phase_done = idx_r == 4'(BLK_BYTES - 1);
      end
      S_DAT: begin
        cur_byte   = job_r.data_byte;
        phase_done = 1'b1;
      end
      S_TRL: begin
        unique case (idx_r)
          4'd0:    cur_byte = job_r.trl_crc[7:0];
          4'd1:    cur_byte = job_r.trl_crc[15:8];
          4'd2:    cur_byte = job_r.trl_crc[23:16];
          4'd3:    cur_byte = job_r.trl_crc[31:24];
          4'd4:    cur_byte = job_r.trl_count[7:0];
          4'd5:    cur_byte = job_r.trl_count[15:8];
          4'd6:    cur_byte = job_r.trl_count[23:16];
          default: cur_byte = job_r.trl_count[31:24];
        endcase
        phase_done = idx_r == 4'(TRL_BYTES - 1);
      end
      default: begin
        cur_byte   = 8'h00;
        phase_done = 1'b0;
      end
    endcase
  end

  assign next_ph = after(job_r, state_r);
  assign adv     = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    job_nxt       = job_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    last_nxt      = last_r;
    end_nxt       = end_r;
    pop_ready     = 1'b0;
    if (state_r == S_IDLE) begin
      pop_ready = 1'b1;
      if (pop_valid) begin
        job_nxt   = pop_data;
        state_nxt = first_phase(pop_data);
        idx_nxt   = 4'd0;
      end
    end else if (adv) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      last_nxt      = phase_done && (next_ph == S_IDLE);
      end_nxt       = (state_r == S_TRL) && phase_done;
      if (phase_done) begin
        idx_nxt = 4'd0;
        if (next_ph == S_IDLE) begin
          pop_ready = 1'b1;
          if (pop_valid) begin
            job_nxt   = pop_data;
            state_nxt = first_phase(pop_data);
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = next_ph;
        end
      end else begin
        idx_nxt = idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_byte_r <= out_byte_nxt;
    last_r     <= last_nxt;
    end_r      <= end_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = last_r;
  assign out_ch.stream_end  = end_r;

endmodule

// File: src/gzip_stored_framer.sv
`timescale 1ns / 1ps
// Top level of the gzip stored-block framer: length register, front end,
// job queue and byte emitter. Depends on gsf_pkg, the channel interfaces and submodules.
//
//   channel   direction  payload
//   in_ch     in         operation, data_byte
//   out_ch    out        out_byte, last_of_run, stream_end
//   cfg_ch    in         total_length (always ready)
//
// An item is taken when the job queue has room; its results leave at one byte per cycle
// unless the output stalls, so a plain data byte sustains one per cycle. A start emits
// the header (with zero length also an empty final block and the trailer), a block
// boundary adds a block header, the stream end the trailer; the emitter sets the rate.
// Reset is synchronous and clears the counters, the CRC and the queue.
// Input stalls once the queue is full; output stalls hold the output register.
module gzip_stored_framer
  import gsf_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  gsf_in_if.sink     in_ch,
  gsf_out_if.source  out_ch,
  gsf_cfg_if.sink    cfg_ch
);

  logic [31:0] total_length_r;
  logic        push_valid, push_ready, pop_valid, pop_ready;
  gsf_job_t    push_data, pop_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_length_r <= 32'd0;
    end else if (cfg_ch.valid) begin
      total_length_r <= cfg_ch.total_length;
    end
  end

  gsf_front #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .total_length(total_length_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  gsf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  gsf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .out_ch   (out_ch)
  );

endmodule

// File: src/gsf_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the gzip stored-block framer and their bind to the top.
// Depends only on the top level's ports.
module gsf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run,
  input logic       stream_end
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
    $stable(last_of_run) && $stable(stream_end))
    else $error("stalled output transaction changed");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stream_end |-> last_of_run)
    else $error("stream end without end of run");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("length register not ready");

endmodule

bind gzip_stored_framer gsf_checker u_gsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_ready  (cfg_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .last_of_run(out_ch.last_of_run),
  .stream_end (out_ch.stream_end)
);
